// File: rtl/matrix_multiply_core_macros.svh
// Assertion macros shared by the matrix multiply core modules.
// Depends on nothing; taken in by the files that carry assertions.
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mmc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control structures of the matrix multiply core.
// Depends on nothing; used by the controller, the datapath and the top level.
package mmc_pkg;

    // Default sizing of the core.
    localparam int DEF_MAX_DIM    = 8;
    localparam int DEF_DATA_WIDTH = 16;

    // Configuration port geometry and size register behaviour.
    localparam int CFG_W      = 4;
    localparam int SIZE_RESET = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // Input transaction modes.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd_en;
        logic clear_acc;
        logic load_out;
        logic out_last;
    } mmc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_empty;
        logic out_free;
    } mmc_status_t;

endpackage

// File: rtl/mmc_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module mmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mmc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the matrix multiply core: element stores, multiply-accumulate
// pipeline and result register. Depends on mmc_pkg, mmc_ram and the macros.
`include "matrix_multiply_core_macros.svh"
module mmc_datapath #(
    parameter int MAX_DIM    = mmc_pkg::DEF_MAX_DIM,
    parameter int DATA_WIDTH = mmc_pkg::DEF_DATA_WIDTH
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  mmc_pkg::mmc_cmd_t                         cmd,
    input  logic [$clog2(MAX_DIM)-1:0]                i_idx,
    input  logic [$clog2(MAX_DIM)-1:0]                j_idx,
    input  logic [$clog2(MAX_DIM)-1:0]                k_idx,
    input  logic [$clog2(MAX_DIM)-1:0]                s_row_pos,
    input  logic [$clog2(MAX_DIM)-1:0]                s_col_pos,
    input  logic signed [DATA_WIDTH-1:0]              s_elem_value,
    output mmc_pkg::mmc_status_t                      status,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [$clog2(MAX_DIM)-1:0]                m_out_row,
    output logic [$clog2(MAX_DIM)-1:0]                m_out_col,
    output logic signed [2*DATA_WIDTH+$clog2(MAX_DIM)-1:0] m_out_value,
    output logic                                      m_last
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);

    logic [DATA_WIDTH-1:0]    a_rdata;
    logic [DATA_WIDTH-1:0]    b_rdata;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic                     out_last_reg;

    // Element stores, addressed by row and column; A is read at (i, k), B at (k, j).
    mmc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .aclk  (aclk),
        .we    (cmd.wr_a),
        .waddr ({s_row_pos, s_col_pos}),
        .wdata (s_elem_value),
        .re    (cmd.rd_en),
        .raddr ({i_idx, k_idx}),
        .rdata (a_rdata)
    );

    mmc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .aclk  (aclk),
        .we    (cmd.wr_b),
        .waddr ({s_row_pos, s_col_pos}),
        .wdata (s_elem_value),
        .re    (cmd.rd_en),
        .raddr ({k_idx, j_idx}),
        .rdata (b_rdata)
    );

    // Multiply stage on the registered read data, then sign extension for the sum.
    assign prod_next = $signed(a_rdata) * $signed(b_rdata);
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Accumulate stage: cleared as the first read of an element is issued.
    always_comb begin
        acc_next = acc_reg;
        if (cmd.clear_acc) begin
            acc_next = '0;
        end else if (v2_reg) begin
            acc_next = acc_reg + prod_ext;
        end
    end

    // Valid flags that track reads through the two pipeline stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Result register: it holds a finished element until the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_row_reg   <= i_idx;
            out_col_reg   <= j_idx;
            out_value_reg <= acc_reg;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign status.pipe_empty = !v1_reg && !v2_reg;
    assign status.out_free   = !out_valid_reg || m_ready;

    assign m_valid     = out_valid_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_out_value = out_value_reg;
    assign m_last      = out_last_reg;

    // A new element must not start while products of the previous one are in flight.
    `MMC_ASSERT_IMP(a_clear_when_empty, aclk, aresetn, cmd.clear_acc, !v1_reg && !v2_reg, "Accumulator cleared with products in flight.")
    // The result must be captured only after the last product has been summed.
    `MMC_ASSERT_IMP(a_load_when_summed, aclk, aresetn, cmd.load_out, !v1_reg && !v2_reg && !cmd.rd_en, "Result captured before its sum was complete.")
    // Loads and compute reads never share a cycle.
    `MMC_ASSERT_IMP(a_no_write_in_compute, aclk, aresetn, cmd.wr_a || cmd.wr_b, !cmd.rd_en && !v1_reg && !v2_reg, "Element store written during a compute.")

endmodule

// File: rtl/mmc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the matrix multiply core: input handshake, load range checks
// and the row, column and inner loop sequencing. Depends on mmc_pkg and the macros.
`include "matrix_multiply_core_macros.svh"
module mmc_ctrl #(
    parameter int MAX_DIM = mmc_pkg::DEF_MAX_DIM
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mmc_pkg::MODE_W-1:0]       s_mode,
    input  logic [$clog2(MAX_DIM)-1:0]       s_row_pos,
    input  logic [$clog2(MAX_DIM)-1:0]       s_col_pos,
    input  logic [$clog2(MAX_DIM+1)-1:0]     rows_a,
    input  logic [$clog2(MAX_DIM+1)-1:0]     inner_len,
    input  logic [$clog2(MAX_DIM+1)-1:0]     cols_b,
    input  mmc_pkg::mmc_status_t             status,
    output mmc_pkg::mmc_cmd_t                cmd,
    output logic [$clog2(MAX_DIM)-1:0]       i_idx,
    output logic [$clog2(MAX_DIM)-1:0]       j_idx,
    output logic [$clog2(MAX_DIM)-1:0]       k_idx
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int SZ_W  = $clog2(MAX_DIM + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [IDX_W-1:0] i_last;
    logic [IDX_W-1:0] j_last;
    logic [IDX_W-1:0] k_last;
    logic             a_in_range;
    logic             b_in_range;
    logic             last_elem;

    // Loop bounds; sizes are never below one.
    assign i_last = IDX_W'(rows_a - 1'b1);
    assign j_last = IDX_W'(cols_b - 1'b1);
    assign k_last = IDX_W'(inner_len - 1'b1);

    // Loads outside the sizes in use are dropped.
    assign a_in_range = (SZ_W'(s_row_pos) < rows_a) && (SZ_W'(s_col_pos) < inner_len);
    assign b_in_range = (SZ_W'(s_row_pos) < inner_len) && (SZ_W'(s_col_pos) < cols_b);
    assign last_elem  = (i_reg == i_last) && (j_reg == j_last);

    // Next state, loop counters and datapath commands.
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        mmc_pkg::MODE_LOAD_A: begin
                            cmd.wr_a = a_in_range;
                        end
                        mmc_pkg::MODE_LOAD_B: begin
                            cmd.wr_b = b_in_range;
                        end
                        mmc_pkg::MODE_COMPUTE: begin
                            state_next = ST_RUN;
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                cmd.rd_en     = 1'b1;
                cmd.clear_acc = (k_reg == '0);
                if (k_reg == k_last) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = IDX_W'(k_reg + 1'b1);
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty && status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = last_elem;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RUN;
                        if (j_reg == j_last) begin
                            j_next = '0;
                            i_next = IDX_W'(i_reg + 1'b1);
                        end else begin
                            j_next = IDX_W'(j_reg + 1'b1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign i_idx   = i_reg;
    assign j_idx   = j_reg;
    assign k_idx   = k_reg;

    // A compute transaction starts the first element at the origin.
    `MMC_ASSERT_NXT(a_compute_starts, aclk, aresetn, s_valid && s_ready && (s_mode == mmc_pkg::MODE_COMPUTE), (state_reg == ST_RUN) && (i_reg == '0) && (j_reg == '0) && (k_reg == '0), "Compute did not start at the first element.")
    // After the final element is captured the controller is idle again.
    `MMC_ASSERT_NXT(a_last_goes_idle, aclk, aresetn, cmd.load_out && cmd.out_last, state_reg == ST_IDLE, "Controller kept running after the final element.")

endmodule

// File: rtl/matrix_multiply_core.sv
`timescale 1ns / 1ps
// Top level of the matrix multiply core: configuration registers on the APB-style
// port and the controller and datapath. Depends on mmc_pkg, mmc_ctrl and mmc_datapath.
//
// Computes C = A x B on signed fixed-point elements with an exact accumulator.
// Mode 0 and mode 1 transactions write one element of A or B at (row, column)
// and are ignored outside the configured sizes; mode 3 is ignored. Loads stream
// at one per clock while no compute runs. A mode 2 transaction emits all
// rows_a*cols_b elements of C in row-major order, marking the last one. For each
// element, one read per inner step is issued to the single read port of each
// element store, then the multiply and accumulate stages drain before the sum is
// moved into the result register; the move waits while that register is still full.
// The input side stays busy for the whole compute; the next transaction is taken
// as soon as the final element is in the result register. The element stores
// start undefined; a compute must only use elements that have been loaded. Size
// registers take 0 as 1 and saturate at MAX_DIM, and must be written only while
// the core is idle.
module matrix_multiply_core #(
    parameter int MAX_DIM    = mmc_pkg::DEF_MAX_DIM,
    parameter int DATA_WIDTH = mmc_pkg::DEF_DATA_WIDTH
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    // Configuration port
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [mmc_pkg::APB_ADDR_W-1:0]                 paddr,
    input  logic [mmc_pkg::APB_DATA_W-1:0]                 pwdata,
    output logic [mmc_pkg::APB_DATA_W-1:0]                 prdata,
    output logic                                           pready,
    // Input channel
    input  logic                                           s_valid,
    output logic                                           s_ready,
    input  logic [mmc_pkg::MODE_W-1:0]                     s_mode,
    input  logic [$clog2(MAX_DIM)-1:0]                     s_row_pos,
    input  logic [$clog2(MAX_DIM)-1:0]                     s_col_pos,
    input  logic signed [DATA_WIDTH-1:0]                   s_elem_value,
    // Result channel
    output logic                                           m_valid,
    input  logic                                           m_ready,
    output logic [$clog2(MAX_DIM)-1:0]                     m_out_row,
    output logic [$clog2(MAX_DIM)-1:0]                     m_out_col,
    output logic signed [2*DATA_WIDTH+$clog2(MAX_DIM)-1:0] m_out_value,
    output logic                                           m_last
);

    localparam int SZ_W     = $clog2(MAX_DIM + 1);
    localparam int SIZE_RST = (mmc_pkg::SIZE_RESET > MAX_DIM) ? MAX_DIM : mmc_pkg::SIZE_RESET;

    logic [SZ_W-1:0]                 rows_a_reg;
    logic [SZ_W-1:0]                 rows_a_next;
    logic [SZ_W-1:0]                 inner_len_reg;
    logic [SZ_W-1:0]                 inner_len_next;
    logic [SZ_W-1:0]                 cols_b_reg;
    logic [SZ_W-1:0]                 cols_b_next;
    logic [mmc_pkg::CFG_W-1:0]       wr_size;
    logic [SZ_W-1:0]                 wr_clamped;
    logic [mmc_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                            cfg_write;
    mmc_pkg::mmc_cmd_t               cmd;
    mmc_pkg::mmc_status_t            status;
    logic [$clog2(MAX_DIM)-1:0]      i_idx;
    logic [$clog2(MAX_DIM)-1:0]      j_idx;
    logic [$clog2(MAX_DIM)-1:0]      k_idx;

    // Register decode; the port never waits.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[mmc_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign wr_size   = pwdata[mmc_pkg::CFG_W-1:0];

    // A written size of zero becomes one, and values above MAX_DIM saturate.
    always_comb begin
        if (wr_size == '0) begin
            wr_clamped = SZ_W'(1);
        end else if (int'(wr_size) > MAX_DIM) begin
            wr_clamped = SZ_W'(MAX_DIM);
        end else begin
            wr_clamped = SZ_W'(wr_size);
        end
    end

    always_comb begin
        rows_a_next    = rows_a_reg;
        inner_len_next = inner_len_reg;
        cols_b_next    = cols_b_reg;
        if (cfg_write) begin
            case (reg_idx)
                mmc_pkg::REG_ROWS_A:    rows_a_next    = wr_clamped;
                mmc_pkg::REG_INNER_LEN: inner_len_next = wr_clamped;
                mmc_pkg::REG_COLS_B:    cols_b_next    = wr_clamped;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= SZ_W'(SIZE_RST);
            inner_len_reg <= SZ_W'(SIZE_RST);
            cols_b_reg    <= SZ_W'(SIZE_RST);
        end else begin
            rows_a_reg    <= rows_a_next;
            inner_len_reg <= inner_len_next;
            cols_b_reg    <= cols_b_next;
        end
    end

    // Read-back of the size registers.
    always_comb begin
        case (reg_idx)
            mmc_pkg::REG_ROWS_A:    prdata = mmc_pkg::APB_DATA_W'(rows_a_reg);
            mmc_pkg::REG_INNER_LEN: prdata = mmc_pkg::APB_DATA_W'(inner_len_reg);
            mmc_pkg::REG_COLS_B:    prdata = mmc_pkg::APB_DATA_W'(cols_b_reg);
            default:                prdata = '0;
        endcase
    end

    // Sequencing of loads and of the compute loops.
    mmc_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_row_pos (s_row_pos),
        .s_col_pos (s_col_pos),
        .rows_a    (rows_a_reg),
        .inner_len (inner_len_reg),
        .cols_b    (cols_b_reg),
        .status    (status),
        .cmd       (cmd),
        .i_idx     (i_idx),
        .j_idx     (j_idx),
        .k_idx     (k_idx)
    );

    // Element stores, multiply-accumulate pipeline and result register.
    mmc_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .i_idx        (i_idx),
        .j_idx        (j_idx),
        .k_idx        (k_idx),
        .s_row_pos    (s_row_pos),
        .s_col_pos    (s_col_pos),
        .s_elem_value (s_elem_value),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_out_value  (m_out_value),
        .m_last       (m_last)
    );

endmodule

// File: test/matrix_multiply_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of matrix_multiply_core: element loads, size settings and products.
// Depends on mmc_pkg and matrix_multiply_core; holds its own product predictor.
module matrix_multiply_core_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int DIM           = 8;
    localparam int VALUE_W       = 35;
    localparam int RANDOM_ITEMS  = 110;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 5_000_000;

    // Mode that the core takes and drops without effect.
    localparam logic [mmc_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;

    // One element of the product matrix as the result channel carries it.
    typedef struct {
        logic [2:0]         row;
        logic [2:0]         col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } product_elem_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [mmc_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [mmc_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [mmc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [mmc_pkg::MODE_W-1:0] s_mode       = mmc_pkg::MODE_LOAD_A;
    logic [2:0]                 s_row_pos    = '0;
    logic [2:0]                 s_col_pos    = '0;
    logic signed [15:0]         s_elem_value = '0;

    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic [2:0]               m_out_row;
    logic [2:0]               m_out_col;
    logic signed [VALUE_W-1:0] m_out_value;
    logic                     m_last;

    // Predictor state: element stores, which entries hold data, sizes in force.
    logic signed [15:0] a_elem [DIM][DIM];
    logic signed [15:0] b_elem [DIM][DIM];
    bit                 a_written [DIM][DIM];
    bit                 b_written [DIM][DIM];
    int unsigned        rows_cfg  = DIM;
    int unsigned        inner_cfg = DIM;
    int unsigned        cols_cfg  = DIM;

    product_elem_t pending_products [$];
    product_elem_t want;
    int            mismatch_count  = 0;
    int            effective_items = 0;
    bit            src_idle_on     = 1'b0;
    bit            sink_idle_on    = 1'b0;
    bit            result_taken    = 1'b0;
    int            sink_gap        = 0;

    matrix_multiply_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_row_pos    (s_row_pos),
        .s_col_pos    (s_col_pos),
        .s_elem_value (s_elem_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_out_value  (m_out_value),
        .m_last       (m_last)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // A size register takes 0 as 1 and saturates at the largest dimension.
    function automatic int unsigned size_in_force(logic [3:0] raw);
        if (raw == 4'd0)
            return 1;
        if (raw > DIM)
            return DIM;
        return raw;
    endfunction

    // Updates the predicted stores for one transaction and queues the product
    // elements that a compute emits. Returns whether the transaction had an effect.
    function automatic bit apply_transaction(logic [mmc_pkg::MODE_W-1:0] mode,
                                             logic [2:0] row, logic [2:0] col,
                                             logic signed [15:0] value);
        longint        acc;
        product_elem_t elem;
        int unsigned   count;
        count = 0;
        case (mode)
            mmc_pkg::MODE_LOAD_A: begin
                if (row >= rows_cfg || col >= inner_cfg)
                    return 1'b0;
                a_elem[row][col]    = value;
                a_written[row][col] = 1'b1;
                return 1'b1;
            end
            mmc_pkg::MODE_LOAD_B: begin
                if (row >= inner_cfg || col >= cols_cfg)
                    return 1'b0;
                b_elem[row][col]    = value;
                b_written[row][col] = 1'b1;
                return 1'b1;
            end
            mmc_pkg::MODE_COMPUTE: begin
                for (int i = 0; i < rows_cfg; i++) begin
                    for (int j = 0; j < cols_cfg; j++) begin
                        acc = 0;
                        for (int k = 0; k < inner_cfg; k++)
                            acc += longint'(a_elem[i][k]) * longint'(b_elem[k][j]);
                        count++;
                        elem.row   = 3'(i);
                        elem.col   = 3'(j);
                        elem.value = acc[VALUE_W-1:0];
                        elem.last  = (count == rows_cfg * cols_cfg);
                        pending_products.push_back(elem);
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Element values lean towards the extremes of signed Q8.8.
    function automatic logic signed [15:0] random_elem();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one input transaction. Entered and left at a falling edge; valid
    // stays high into the next transaction when no gap is drawn.
    task automatic send_item(logic [mmc_pkg::MODE_W-1:0] mode, logic [2:0] row,
                             logic [2:0] col, logic signed [15:0] value);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        if (apply_transaction(mode, row, col, value))
            effective_items++;
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_row_pos    <= row;
        s_col_pos    <= col;
        s_elem_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Waits until every product element has come back and the core has settled.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes one size register over the configuration port; only while idle.
    task automatic write_size(logic [mmc_pkg::REG_IDX_W-1:0] reg_idx, logic [3:0] raw);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= mmc_pkg::APB_DATA_W'(raw);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            mmc_pkg::REG_ROWS_A:    rows_cfg  = size_in_force(raw);
            mmc_pkg::REG_INNER_LEN: inner_cfg = size_in_force(raw);
            mmc_pkg::REG_COLS_B:    cols_cfg  = size_in_force(raw);
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_sizes(logic [3:0] rows_raw, logic [3:0] inner_raw, logic [3:0] cols_raw);
        write_size(mmc_pkg::REG_ROWS_A, rows_raw);
        write_size(mmc_pkg::REG_INNER_LEN, inner_raw);
        write_size(mmc_pkg::REG_COLS_B, cols_raw);
    endtask

    // Result channel: each transaction draws how long ready stays low afterwards.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_taken = 1'b1;
            if (pending_products.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result: row %0d col %0d value %0d last %0b",
                             m_out_row, m_out_col, m_out_value, m_last);
            end else begin
                want = pending_products.pop_front();
                if (m_out_row !== want.row || m_out_col !== want.col ||
                    m_out_value !== want.value || m_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"Result mismatch: expected row %0d col %0d value %0d",
                                  " last %0b, got row %0d col %0d value %0d last %0b"},
                                 want.row, want.col, $signed(want.value), want.last,
                                 m_out_row, m_out_col, m_out_value, m_last);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (result_taken)
            sink_gap = sink_idle_on ? $urandom_range(0, 6) : 0;
        result_taken = 1'b0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            m_ready <= 1'b0;
            sink_gap--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Largest sums: a full inner length of the most negative value, against both
    // extremes. Also checks that a size of 0 reads as 1 and 15 saturates.
    task automatic test_extreme_sums();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_sizes(4'd0, 4'd15, 4'd2);
        for (int k = 0; k < DIM; k++)
            send_item(mmc_pkg::MODE_LOAD_A, 3'd0, 3'(k), 16'sh8000);
        for (int k = 0; k < DIM; k++) begin
            send_item(mmc_pkg::MODE_LOAD_B, 3'(k), 3'd0, 16'sh8000);
            send_item(mmc_pkg::MODE_LOAD_B, 3'(k), 3'd1, 16'sh7fff);
        end
        send_item(mmc_pkg::MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
    endtask

    // Loads outside the sizes in force and mode three leave the stores alone.
    task automatic test_ignored_items();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        set_sizes(4'd1, 4'd1, 4'd0);
        send_item(mmc_pkg::MODE_LOAD_A, 3'd0, 3'd0, 16'sh0180);
        send_item(mmc_pkg::MODE_LOAD_B, 3'd0, 3'd0, -16'sh0240);
        send_item(mmc_pkg::MODE_LOAD_A, 3'd7, 3'd0, 16'sh7fff);
        send_item(mmc_pkg::MODE_LOAD_A, 3'd0, 3'd7, 16'sh7fff);
        send_item(mmc_pkg::MODE_LOAD_B, 3'd7, 3'd0, 16'sh8000);
        send_item(mmc_pkg::MODE_LOAD_B, 3'd0, 3'd7, 16'sh8000);
        send_item(MODE_IGNORED, 3'd7, 3'd7, 16'shffff);
        send_item(mmc_pkg::MODE_COMPUTE, 3'd7, 3'd7, 16'shffff);
        wait_idle();
    endtask

    // Growing the sizes brings back entries loaded earlier under other sizes.
    task automatic test_size_change();
        set_sizes(4'd1, 4'd3, 4'd2);
        send_item(mmc_pkg::MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
    endtask

    // Random sizes pick mostly small matrices, now and then a clamped or full one.
    function automatic logic [3:0] random_size();
        case ($urandom_range(0, 9))
            0: return 4'd0;
            1: return 4'($urandom_range(9, 15));
            2: return 4'd8;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // Any transaction that is not a compute, mostly out of range or ignored.
    task automatic maybe_noise();
        logic [mmc_pkg::MODE_W-1:0] mode;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
                0: mode = mmc_pkg::MODE_LOAD_A;
                1: mode = mmc_pkg::MODE_LOAD_B;
                default: mode = MODE_IGNORED;
            endcase
            send_item(mode, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), random_elem());
        end
    endtask

    // Loads every entry that the next compute reads and has not been written,
    // and refreshes some of the others.
    task automatic load_operands();
        for (int i = 0; i < rows_cfg; i++) begin
            for (int k = 0; k < inner_cfg; k++) begin
                if (!a_written[i][k] || $urandom_range(0, 2) == 0) begin
                    maybe_noise();
                    send_item(mmc_pkg::MODE_LOAD_A, 3'(i), 3'(k), random_elem());
                end
            end
        end
        for (int k = 0; k < inner_cfg; k++) begin
            for (int j = 0; j < cols_cfg; j++) begin
                if (!b_written[k][j] || $urandom_range(0, 2) == 0) begin
                    maybe_noise();
                    send_item(mmc_pkg::MODE_LOAD_B, 3'(k), 3'(j), random_elem());
                end
            end
        end
    endtask

    // Random jobs: new sizes while idle, operand loads, then one or two computes.
    // Now and then a job stops after its loads.
    task automatic test_random_jobs();
        int target;
        int shape;
        target = effective_items + RANDOM_ITEMS;
        while (effective_items < target) begin
            if ($urandom_range(0, 3) != 0) begin
                wait_idle();
                set_sizes(random_size(), random_size(), random_size());
            end
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            load_operands();
            shape = $urandom_range(0, 9);
            if (shape != 0) begin
                maybe_noise();
                send_item(mmc_pkg::MODE_COMPUTE, 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), random_elem());
            end
            if (shape == 1)
                send_item(mmc_pkg::MODE_COMPUTE, 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), random_elem());
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_extreme_sums();
        test_ignored_items();
        test_size_change();
        test_random_jobs();
        wait_idle();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
